// ----- sv/pgrs_pkg.sv -----
// Shared types and constants for the PCM gain ramp with saturation block.
// No dependencies; every other file imports this package.
package pgrs_pkg;

  localparam int SAMPLE_W       = 16;
  localparam int GAIN_W         = 16;
  localparam int GAIN_FRAC_BITS = 12;
  localparam int STEP_FRAC_BITS = 15;
  localparam int STEP_W         = 32;
  localparam int POS_W          = 15;
  localparam int CH_CFG_W       = 4;
  localparam int SPC_W          = 13;
  localparam int CFG_DATA_W     = 13;
  localparam int CFG_INDEX_W    = 1;
  localparam int QUO_W          = GAIN_W + STEP_FRAC_BITS;
  localparam int ACC_W          = 48;
  localparam int HALF_W         = ACC_W / 2;
  localparam int PROD_W         = SAMPLE_W + ACC_W;
  localparam int THRESH_W       = 36;

  localparam logic [GAIN_W-1:0]   UNITY_GAIN = GAIN_W'(1 << GAIN_FRAC_BITS);
  localparam logic [THRESH_W-1:0] STEP_LIMIT = THRESH_W'(1000000);
  localparam logic [PROD_W-1:0]   ROUND_HALF = PROD_W'(1 << (GAIN_FRAC_BITS - 1));
  localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAT_MIN = 16'sh8000;

  localparam logic [CH_CFG_W-1:0] CH_RESET  = CH_CFG_W'(2);
  localparam logic [SPC_W-1:0]    SPC_RESET = SPC_W'(1024);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CHANNEL_COUNT       = 1'b0,
    REG_SAMPLES_PER_CHANNEL = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_PASS  = 2'd0,
    MODE_CONST = 2'd1,
    MODE_RAMP  = 2'd2
  } mode_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    mode_t                      mode;
    logic [GAIN_W-1:0]          base_gain;
    logic signed [STEP_W-1:0]   gain_step;
    logic [POS_W-1:0]           pos_plus1;
  } job_t;

endpackage

// ----- sv/pgrs_if.sv -----
// Sample and result channel interfaces with valid/ready handshake.
// Depends on pgrs_pkg for field widths.
interface pgrs_sample_if;
  import pgrs_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       frame_start;
  logic [GAIN_W-1:0]          start_gain;
  logic [GAIN_W-1:0]          end_gain;

  modport source (output valid, sample, frame_start, start_gain, end_gain, input ready);
  modport sink   (input valid, sample, frame_start, start_gain, end_gain, output ready);
endinterface

interface pgrs_result_if;
  import pgrs_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] scaled_sample;
  logic                       clipped;

  modport source (output valid, scaled_sample, clipped, input ready);
  modport sink   (input valid, scaled_sample, clipped, output ready);
endinterface

// ----- sv/pcm_gain_ramp_saturate_top.sv -----
// Top level of the PCM gain ramp with saturation block: configuration
// registers, front end, job queue and back end. Uses pgrs_pkg, pgrs_if.
//
// Usage:
//   samples carries one interleaved PCM word per handshake; frame_start marks
//   the first word of a frame, and start_gain/end_gain (Q4.12) are read then.
//   results returns one scaled, saturated word per accepted word, in order,
//   with clipped set when the value was limited to the 16-bit range.
//   cfg_we/cfg_index/cfg_wdata write channel_count (index 0) and
//   samples_per_channel (index 1); write them only while the block is idle.
// Processing:
//   An accepted word passes through the front end, the job queue and the
//   back end, which works on one word at a time (gain, magnitude, multiply,
//   round/saturate) and takes no new job until its result is loaded. A frame
//   start that opens a ramp also waits in the front-end step divider.
// Reset and stall:
//   Reset sets channel_count to 2, samples_per_channel to 1024, clears all
//   counters and selects pass-through until the first frame start.
//   When results stalls, the output register holds its word, the two-entry
//   job queue fills, and samples.ready drops once the front end is blocked.
module pcm_gain_ramp_saturate_top #(
  parameter int MAX_CHANNELS      = 8,
  parameter int MAX_FRAME_SAMPLES = 4096
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [pgrs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pgrs_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  pgrs_sample_if.sink                      samples,
  pgrs_result_if.source                    results
);
  import pgrs_pkg::*;

  logic [CH_CFG_W-1:0] channel_count;
  logic [SPC_W-1:0]    samples_per_channel;
  job_t                front_job;
  logic                front_valid;
  logic                front_ready;
  job_t                queue_job;
  logic                queue_valid;
  logic                queue_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count       <= CH_RESET;
      samples_per_channel <= SPC_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CHANNEL_COUNT:       channel_count       <= cfg_wdata[CH_CFG_W-1:0];
        REG_SAMPLES_PER_CHANNEL: samples_per_channel <= cfg_wdata[SPC_W-1:0];
        default: ;
      endcase
    end
  end

  pgrs_front #(
    .MAX_CHANNELS      (MAX_CHANNELS),
    .MAX_FRAME_SAMPLES (MAX_FRAME_SAMPLES)
  ) u_front (
    .clk                 (clk),
    .rst                 (rst),
    .channel_count       (channel_count),
    .samples_per_channel (samples_per_channel),
    .samples             (samples),
    .job                 (front_job),
    .job_valid           (front_valid),
    .job_ready           (front_ready)
  );

  pgrs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_job   (front_job),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .rd_job   (queue_job),
    .rd_valid (queue_valid),
    .rd_ready (queue_ready)
  );

  pgrs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (queue_job),
    .job_valid (queue_valid),
    .job_ready (queue_ready),
    .results   (results)
  );

endmodule

// ----- sv/pgrs_div.sv -----
// Restoring divider, one quotient bit per cycle, for the ramp step.
// Depends on pgrs_pkg.
module pgrs_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [pgrs_pkg::QUO_W-1:0] dividend,
  input  logic [pgrs_pkg::SPC_W-1:0] divisor,
  output logic                       done,
  output logic [pgrs_pkg::QUO_W-1:0] quotient
);
  import pgrs_pkg::*;

  localparam int CNT_W = $clog2(QUO_W);

  logic             busy;
  logic [CNT_W-1:0] count;
  logic [QUO_W-1:0] num;
  logic [SPC_W-1:0] rem;
  logic [SPC_W-1:0] dvs;
  logic [SPC_W:0]   trial;
  logic             fits;
  logic [SPC_W-1:0] rem_next;

  assign trial    = {rem, num[QUO_W-1]};
  assign fits     = trial >= {1'b0, dvs};
  assign rem_next = fits ? SPC_W'(trial - {1'b0, dvs}) : SPC_W'(trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= !start && busy && (count == '0);
      if (start) begin
        busy     <= 1'b1;
        count    <= CNT_W'(QUO_W - 1);
        num      <= dividend;
        rem      <= '0;
        dvs      <= divisor;
        quotient <= '0;
      end else if (busy) begin
        rem      <= rem_next;
        num      <= {num[QUO_W-2:0], 1'b0};
        quotient <= {quotient[QUO_W-2:0], fits};
        count    <= count - CNT_W'(1);
        if (count == '0) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

// ----- sv/pgrs_front.sv -----
// Front end: accepts sample words, latches frame gains, picks the mode,
// tracks channel and position counters and issues jobs. Uses pgrs_pkg, pgrs_div.
module pgrs_front #(
  parameter int MAX_CHANNELS      = 8,
  parameter int MAX_FRAME_SAMPLES = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [pgrs_pkg::CH_CFG_W-1:0] channel_count,
  input  logic [pgrs_pkg::SPC_W-1:0]    samples_per_channel,
  pgrs_sample_if.sink                   samples,
  output pgrs_pkg::job_t                job,
  output logic                          job_valid,
  input  logic                          job_ready
);
  import pgrs_pkg::*;

  localparam int PW = $clog2(MAX_FRAME_SAMPLES);
  localparam int CW = $clog2(MAX_CHANNELS + 1);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_ISSUE, S_PUSH} state_t;

  state_t                     state;
  mode_t                      mode;
  logic [GAIN_W-1:0]          base_gain;
  logic signed [STEP_W-1:0]   gain_step;
  logic [PW-1:0]              position;
  logic [CW-1:0]              chan;
  logic signed [SAMPLE_W-1:0] held;
  logic                       step_neg;

  logic [4:0]                 ch_eff;
  logic [SPC_W-1:0]           spc_eff;
  logic signed [GAIN_W:0]     diff;
  logic [GAIN_W-1:0]          adiff;
  logic                       below;
  logic [CW:0]                chan_inc;
  logic [PW:0]                pos_inc;
  logic                       accept;
  logic                       div_start;
  logic                       div_done;
  logic [QUO_W-1:0]           quotient;
  logic signed [STEP_W-1:0]   step_mag;

  always_comb begin
    if (channel_count == '0) begin
      ch_eff = 5'd1;
    end else if ({1'b0, channel_count} > 5'(MAX_CHANNELS)) begin
      ch_eff = 5'(MAX_CHANNELS);
    end else begin
      ch_eff = {1'b0, channel_count};
    end
  end

  always_comb begin
    if (samples_per_channel == '0) begin
      spc_eff = SPC_W'(1);
    end else if (16'(samples_per_channel) > 16'(MAX_FRAME_SAMPLES)) begin
      spc_eff = SPC_W'(MAX_FRAME_SAMPLES);
    end else begin
      spc_eff = samples_per_channel;
    end
  end

  assign diff     = $signed({1'b0, samples.end_gain}) - $signed({1'b0, samples.start_gain});
  assign adiff    = diff[GAIN_W] ? GAIN_W'(-diff) : diff[GAIN_W-1:0];
  assign below    = (THRESH_W'(adiff) * STEP_LIMIT) < (THRESH_W'(spc_eff) << GAIN_FRAC_BITS);
  assign chan_inc = (CW + 1)'(chan) + (CW + 1)'(1);
  assign pos_inc  = (PW + 1)'(position) + (PW + 1)'(1);
  assign step_mag = $signed({1'b0, quotient});

  assign samples.ready = (state == S_IDLE);
  assign accept        = samples.valid && samples.ready;
  assign div_start     = accept && samples.frame_start && (diff != '0) && !below;
  assign job_valid     = (state == S_PUSH);

  pgrs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({adiff, {STEP_FRAC_BITS{1'b0}}}),
    .divisor  (spc_eff),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mode      <= MODE_PASS;
      base_gain <= '0;
      gain_step <= '0;
      position  <= '0;
      chan      <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            held     <= samples.sample;
            step_neg <= diff[GAIN_W];
            state    <= div_start ? S_DIV : S_ISSUE;
            if (samples.frame_start) begin
              position  <= '0;
              chan      <= '0;
              gain_step <= '0;
              if (diff == '0) begin
                base_gain <= samples.start_gain;
                mode      <= (samples.start_gain == UNITY_GAIN) ? MODE_PASS : MODE_CONST;
              end else if (below) begin
                base_gain <= samples.end_gain;
                mode      <= (samples.end_gain == UNITY_GAIN) ? MODE_PASS : MODE_CONST;
              end else begin
                base_gain <= samples.start_gain;
                mode      <= MODE_RAMP;
              end
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            gain_step <= step_neg ? -step_mag : step_mag;
            state     <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          job.sample    <= held;
          job.mode      <= mode;
          job.base_gain <= base_gain;
          job.gain_step <= gain_step;
          job.pos_plus1 <= POS_W'(pos_inc);
          if (mode == MODE_CONST || mode == MODE_RAMP) begin
            if (5'(chan_inc) >= ch_eff) begin
              chan <= '0;
              if (16'(pos_inc) >= 16'(spc_eff)) begin
                position <= '0;
                mode     <= MODE_PASS;
              end else begin
                position <= PW'(pos_inc);
              end
            end else begin
              chan <= CW'(chan_inc);
            end
          end
          state <= S_PUSH;
        end
        S_PUSH: begin
          if (job_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/pgrs_queue.sv -----
// Two-entry job queue between the front end and the back end.
// Depends on pgrs_pkg for the job type.
module pgrs_queue (
  input  logic           clk,
  input  logic           rst,
  input  pgrs_pkg::job_t wr_job,
  input  logic           wr_valid,
  output logic           wr_ready,
  output pgrs_pkg::job_t rd_job,
  output logic           rd_valid,
  input  logic           rd_ready
);
  import pgrs_pkg::*;

  localparam int DEPTH = 2;
  localparam int AW    = $clog2(DEPTH);

  job_t          entries [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;
  logic          push;
  logic          pop;

  assign wr_ready = (count != (AW + 1)'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_job   = entries[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      count <= count + (AW + 1)'(push) - (AW + 1)'(pop);
    end
  end

endmodule

// ----- sv/pgrs_back.sv -----
// Back end: constant or ramp gain, magnitude multiply, rounding for
// constant gain, saturation, output register. Uses pgrs_pkg and pgrs_if.
module pgrs_back (
  input  logic           clk,
  input  logic           rst,
  input  pgrs_pkg::job_t job,
  input  logic           job_valid,
  output logic           job_ready,
  pgrs_result_if.source  results
);
  import pgrs_pkg::*;

  localparam int QW  = PROD_W - GAIN_FRAC_BITS - STEP_FRAC_BITS;
  localparam int PLW = SAMPLE_W + HALF_W;

  typedef enum logic [2:0] {S_IDLE, S_ACC, S_MAG, S_MUL, S_FIN} state_t;

  state_t                     state;
  job_t                       cur;
  logic signed [ACC_W-1:0]    acc;
  logic [ACC_W-1:0]           mag;
  logic                       neg;
  logic [SAMPLE_W-1:0]        mag_s;
  logic [PLW-1:0]             prod_lo;
  logic [PLW-1:0]             prod_hi;
  logic                       out_valid;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic                       out_clip;

  logic signed [POS_W:0]      pos_s;
  logic signed [ACC_W-1:0]    step_term;
  logic signed [ACC_W-1:0]    base_term;
  logic signed [ACC_W-1:0]    acc_next;
  logic [ACC_W-1:0]           acc_mag;
  logic [SAMPLE_W-1:0]        sample_mag;
  logic [PROD_W-1:0]          prod_sum;
  logic [PROD_W-1:0]          rounded;
  logic [QW-1:0]              qmag;
  logic signed [SAMPLE_W-1:0] res_sample;
  logic                       res_clip;
  logic                       out_load;

  assign pos_s      = $signed({1'b0, cur.pos_plus1});
  assign step_term  = pos_s * cur.gain_step;
  assign base_term  = $signed({{(ACC_W - GAIN_W - STEP_FRAC_BITS){1'b0}}, cur.base_gain,
                               {STEP_FRAC_BITS{1'b0}}});
  assign acc_next   = base_term + step_term;
  assign acc_mag    = acc[ACC_W-1] ? ACC_W'(-acc) : acc;
  assign sample_mag = SAMPLE_W'(-cur.sample);
  assign prod_sum   = PROD_W'(prod_lo) + {prod_hi, {HALF_W{1'b0}}};
  assign rounded    = prod_sum + ROUND_HALF;

  always_comb begin
    if (cur.mode == MODE_RAMP) begin
      qmag = prod_sum[PROD_W-1 -: QW];
    end else begin
      qmag = rounded[GAIN_FRAC_BITS +: QW];
    end
  end

  always_comb begin
    res_sample = cur.sample;
    res_clip   = 1'b0;
    case (cur.mode)
      MODE_CONST, MODE_RAMP: begin
        if (neg) begin
          if (qmag > QW'(32768)) begin
            res_sample = SAT_MIN;
            res_clip   = 1'b1;
          end else begin
            res_sample = SAMPLE_W'(QW'(0) - qmag);
          end
        end else begin
          if (qmag > QW'(32767)) begin
            res_sample = SAT_MAX;
            res_clip   = 1'b1;
          end else begin
            res_sample = qmag[SAMPLE_W-1:0];
          end
        end
      end
      default: begin
        res_sample = cur.sample;
        res_clip   = 1'b0;
      end
    endcase
  end

  assign job_ready             = (state == S_IDLE);
  assign out_load              = (state == S_FIN) && (!out_valid || results.ready);
  assign results.valid         = out_valid;
  assign results.scaled_sample = out_sample;
  assign results.clipped       = out_clip;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (results.valid && results.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (job_valid) begin
            cur   <= job;
            state <= S_ACC;
          end
        end
        S_ACC: begin
          acc   <= acc_next;
          state <= S_MAG;
        end
        S_MAG: begin
          mag_s <= cur.sample[SAMPLE_W-1] ? sample_mag : cur.sample;
          if (cur.mode == MODE_RAMP) begin
            mag <= acc_mag;
            neg <= cur.sample[SAMPLE_W-1] ^ acc[ACC_W-1];
          end else begin
            mag <= ACC_W'(cur.base_gain);
            neg <= cur.sample[SAMPLE_W-1];
          end
          state <= S_MUL;
        end
        S_MUL: begin
          prod_lo <= mag_s * mag[HALF_W-1:0];
          prod_hi <= mag_s * mag[ACC_W-1:HALF_W];
          state   <= S_FIN;
        end
        S_FIN: begin
          if (out_load) begin
            out_sample <= res_sample;
            out_clip   <= res_clip;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/pgrs_checker.sv -----
// Port-level checker for the PCM gain ramp block, bound to the top level.
// Depends on pgrs_pkg.
module pgrs_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  in_valid,
  input logic                                  in_ready,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic signed [pgrs_pkg::SAMPLE_W-1:0]  scaled_sample,
  input logic                                  clipped
);
  import pgrs_pkg::*;

  localparam int MAX_IN_FLIGHT = 5;

  logic [2:0] pending;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 3'(in_acc) - 3'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(scaled_sample) && $stable(clipped))
    else $error("result word changed while stalled");

  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != '0)
    else $error("result word without an accepted sample");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    pending <= 3'(MAX_IN_FLIGHT))
    else $error("too many words in flight");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  a_clip: assert property (@(posedge clk) disable iff (rst)
    out_valid && clipped |-> scaled_sample == SAT_MAX || scaled_sample == SAT_MIN)
    else $error("clip flag on unsaturated word");

endmodule

bind pcm_gain_ramp_saturate_top pgrs_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (samples.valid),
  .in_ready      (samples.ready),
  .out_valid     (results.valid),
  .out_ready     (results.ready),
  .scaled_sample (results.scaled_sample),
  .clipped       (results.clipped)
);

// ----- dv/pcm_gain_ramp_saturate_top_tb.sv -----
// Testbench for pcm_gain_ramp_saturate_top: directed and random PCM frames with a
// word-level model of pass-through, constant gain and ramp scaling with saturation.
// Depends on pgrs_pkg and the pgrs_sample_if / pgrs_result_if interfaces.
module pcm_gain_ramp_saturate_top_tb;
  import pgrs_pkg::*;

  localparam int MAX_LANES   = 8;
  localparam int MAX_FRAME   = 4096;
  localparam int HOLD_CYCLES = 200;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic signed [SAMPLE_W-1:0] scaled;
    logic                       clipped;
  } scaled_word_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  pgrs_sample_if samples ();
  pgrs_result_if results ();

  pcm_gain_ramp_saturate_top #(
    .MAX_CHANNELS      (MAX_LANES),
    .MAX_FRAME_SAMPLES (MAX_FRAME)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .samples   (samples),
    .results   (results)
  );

  always #5 clk = ~clk;

  // gain model state and register copies
  logic [CH_CFG_W-1:0]      reg_channels = CH_RESET;
  logic [SPC_W-1:0]         reg_spc      = SPC_RESET;
  mode_t                    cur_mode     = MODE_PASS;
  logic [GAIN_W-1:0]        cur_base     = '0;
  logic signed [STEP_W-1:0] cur_step     = '0;
  int unsigned              cur_pos      = 0;
  int unsigned              cur_lane     = 0;

  scaled_word_t pending_scaled[$];
  logic gaps_on      = 1'b0;
  logic hold_results = 1'b0;
  int   errors       = 0;
  int   words_sent   = 0;
  int   words_checked = 0;
  int   frames_started = 0;
  int   clips_seen   = 0;
  int   reg_writes   = 0;
  int   cycle_count  = 0;

  function automatic int unsigned lanes();
    if (reg_channels == 0) return 1;
    if (reg_channels > MAX_LANES) return MAX_LANES;
    return reg_channels;
  endfunction

  function automatic int unsigned frame_samples();
    if (reg_spc == 0) return 1;
    if (reg_spc > MAX_FRAME) return MAX_FRAME;
    return reg_spc;
  endfunction

  function automatic void latch_frame_gains(logic [GAIN_W-1:0] g0, logic [GAIN_W-1:0] g1);
    longint diff, span, quo;
    diff = longint'(g1) - longint'(g0);
    span = (diff < 0) ? -diff : diff;
    cur_pos  = 0;
    cur_lane = 0;
    cur_step = '0;
    if (diff == 0) begin
      cur_base = g0;
      cur_mode = (g0 == UNITY_GAIN) ? MODE_PASS : MODE_CONST;
    end else if (span * longint'(STEP_LIMIT) <
                 (longint'(frame_samples()) <<< GAIN_FRAC_BITS)) begin
      cur_base = g1;
      cur_mode = (g1 == UNITY_GAIN) ? MODE_PASS : MODE_CONST;
    end else begin
      quo = (span <<< STEP_FRAC_BITS) / longint'(frame_samples());
      cur_base = g0;
      cur_step = STEP_W'((diff < 0) ? -quo : quo);
      cur_mode = MODE_RAMP;
    end
  endfunction

  function automatic scaled_word_t apply_gain(logic signed [SAMPLE_W-1:0] smp, logic fs,
                                              logic [GAIN_W-1:0] g0, logic [GAIN_W-1:0] g1);
    scaled_word_t w;
    longint v, mag, acc, prod, r;
    v = longint'(smp);
    if (fs) latch_frame_gains(g0, g1);
    mag = (v < 0) ? -v : v;
    r = v;
    if (cur_mode == MODE_CONST) begin
      prod = (mag * longint'(cur_base) + (longint'(1) <<< (GAIN_FRAC_BITS - 1)))
             >>> GAIN_FRAC_BITS;
      r = (v < 0) ? -prod : prod;
    end else if (cur_mode == MODE_RAMP) begin
      acc  = (longint'(cur_base) <<< STEP_FRAC_BITS)
             + longint'(cur_pos + 1) * longint'(cur_step);
      prod = (mag * ((acc < 0) ? -acc : acc)) >>> (GAIN_FRAC_BITS + STEP_FRAC_BITS);
      r = ((v < 0) != (acc < 0)) ? -prod : prod;
    end
    w.clipped = 1'b0;
    if (r > longint'(SAT_MAX)) begin
      r = longint'(SAT_MAX);
      w.clipped = 1'b1;
    end else if (r < longint'(SAT_MIN)) begin
      r = longint'(SAT_MIN);
      w.clipped = 1'b1;
    end
    w.scaled = SAMPLE_W'(r);
    if (cur_mode == MODE_CONST || cur_mode == MODE_RAMP) begin
      cur_lane++;
      if (cur_lane >= lanes()) begin
        cur_lane = 0;
        cur_pos++;
        if (cur_pos >= frame_samples()) begin
          cur_pos  = 0;
          cur_mode = MODE_PASS;
        end
      end
    end
    return w;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(0, 7))
      0: return SAT_MAX;
      1: return SAT_MIN;
      2: return SAMPLE_W'(int'($urandom_range(0, 4)) - 2);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic void pick_gains(output logic [GAIN_W-1:0] g0,
                                     output logic [GAIN_W-1:0] g1);
    g0 = GAIN_W'($urandom);
    g1 = GAIN_W'($urandom);
    case ($urandom_range(0, 9))
      0: begin
        g0 = UNITY_GAIN;
        g1 = UNITY_GAIN;
      end
      1: g1 = g0;
      2: g1 = g0 + GAIN_W'($urandom_range(1, 16));
      3: g1 = g0 - GAIN_W'($urandom_range(1, 16));
      4: begin
        g0 = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        g1 = $urandom_range(0, 1) ? 16'hFFFF : UNITY_GAIN;
      end
      5: begin
        g1 = UNITY_GAIN;
        g0 = UNITY_GAIN + GAIN_W'($urandom_range(0, 8)) - GAIN_W'(4);
      end
      default: ;
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_channels();
    int k = $urandom_range(0, 19);
    if (k == 0) return '0;
    if (k == 1) return CFG_DATA_W'($urandom_range(9, 15));
    if (k == 2) return CFG_DATA_W'($urandom);
    return CFG_DATA_W'($urandom_range(1, 8));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_frame_len();
    int k = $urandom_range(0, 19);
    if (k == 0) return '0;
    if (k == 1) return CFG_DATA_W'($urandom_range(4096, 8191));
    if (k <= 3) return CFG_DATA_W'($urandom_range(245, 600));
    if (k <= 6) return CFG_DATA_W'($urandom_range(9, 64));
    return CFG_DATA_W'($urandom_range(1, 8));
  endfunction

  task automatic send_word(logic signed [SAMPLE_W-1:0] smp, logic fs,
                           logic [GAIN_W-1:0] g0, logic [GAIN_W-1:0] g1);
    scaled_word_t expected_word;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      samples.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    samples.valid       <= 1'b1;
    samples.sample      <= smp;
    samples.frame_start <= fs;
    samples.start_gain  <= g0;
    samples.end_gain    <= g1;
    do @(posedge clk); while (!samples.ready);
    expected_word = apply_gain(smp, fs, g0, g1);
    pending_scaled.insert(pending_scaled.size(), expected_word);
    words_sent++;
    if (fs) frames_started++;
  endtask

  task automatic send_cont(logic signed [SAMPLE_W-1:0] smp);
    send_word(smp, 1'b0, GAIN_W'($urandom), GAIN_W'($urandom));
  endtask

  task automatic wait_drained();
    samples.valid <= 1'b0;
    while (pending_scaled.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic program_regs(logic [CFG_DATA_W-1:0] ch_val, logic [CFG_DATA_W-1:0] spc_val);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= REG_CHANNEL_COUNT;
    cfg_wdata <= ch_val;
    @(posedge clk);
    cfg_index <= REG_SAMPLES_PER_CHANNEL;
    cfg_wdata <= spc_val;
    @(posedge clk);
    cfg_we <= 1'b0;
    reg_channels = ch_val[CH_CFG_W-1:0];
    reg_spc      = spc_val;
    reg_writes += 2;
  endtask

  task automatic test_reset_defaults();
    send_cont(SAT_MIN);
    send_cont(SAT_MAX);
    send_word(16'sd20000, 1'b1, 16'hFFFF, 16'h0001);
    send_cont(-16'sd20000);
    send_cont(16'sd7);
  endtask

  task automatic test_directed_modes();
    program_regs(13'd1, 13'd2);
    send_word(SAT_MAX, 1'b1, UNITY_GAIN, UNITY_GAIN);
    send_word(SAT_MIN, 1'b1, 16'h0000, 16'h0000);
    send_word(SAT_MAX, 1'b1, 16'hFFFF, 16'hFFFF);
    send_cont(SAT_MIN);
    send_cont(16'sd12345);
    send_word(SAT_MAX, 1'b1, 16'h0000, 16'hFFFF);
    send_cont(SAT_MIN);
    send_word(-16'sd1, 1'b1, 16'hFFFF, 16'h0000);
    send_cont(16'sd1);
    send_word(16'sd1, 1'b1, 16'h0800, 16'h0800);
    send_cont(-16'sd3);
  endtask

  task automatic test_register_limits();
    program_regs(13'd0, 13'd0);
    send_word(16'sd1000, 1'b1, 16'h2000, UNITY_GAIN);
    send_cont(16'sd1000);
    program_regs(13'd15, 13'd8191);
    send_word(16'sd30000, 1'b1, UNITY_GAIN, 16'h1004);
    send_word(-16'sd5, 1'b1, 16'h0FFA, UNITY_GAIN);
    send_word(SAT_MIN, 1'b1, 16'h0000, 16'h8000);
    send_cont(SAT_MAX);
  endtask

  task automatic test_output_stall();
    logic [GAIN_W-1:0] g0, g1;
    program_regs(13'd3, 13'd4);
    gaps_on      = 1'b0;
    hold_results = 1'b1;
    repeat (3) begin
      pick_gains(g0, g1);
      send_word(random_sample(), 1'b1, g0, g1);
      repeat (11) send_cont(random_sample());
    end
  endtask

  task automatic test_random_frames(int words, logic allow_gaps);
    int goal, len, kind;
    logic [GAIN_W-1:0] g0, g1;
    goal = words_sent + words;
    while (words_sent < goal) begin
      program_regs(pick_channels(), pick_frame_len());
      gaps_on = allow_gaps && ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(2, 6)) begin
        pick_gains(g0, g1);
        len = lanes() * frame_samples();
        if (len > 48) len = $urandom_range(16, 48);
        kind = $urandom_range(0, 9);
        if (kind == 0) len = $urandom_range(1, len);
        else if (kind == 1) len += $urandom_range(1, 4);
        if (kind == 2) begin
          repeat ($urandom_range(1, 6))
            send_word(random_sample(), $urandom_range(0, 2) == 0,
                      GAIN_W'($urandom), GAIN_W'($urandom));
        end else begin
          send_word(random_sample(), 1'b1, g0, g1);
          repeat (len - 1) send_cont(random_sample());
        end
      end
    end
  endtask

  initial begin : drive_result_ready
    results.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_results) begin
        hold_results = 1'b0;
        results.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (gaps_on && $urandom_range(0, 3) == 0) begin
        results.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        results.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : check_results
    scaled_word_t want;
    if (!rst && results.valid && results.ready) begin
      if (pending_scaled.size() == 0) begin
        $display("%0t: unexpected word scaled_sample=%0d clipped=%0b", $time,
                 results.scaled_sample, results.clipped);
        errors++;
      end else begin
        want = pending_scaled.pop_front();
        if (results.scaled_sample !== want.scaled) begin
          $display("%0t: scaled_sample expected %0d actual %0d", $time,
                   want.scaled, results.scaled_sample);
          errors++;
        end
        if (results.clipped !== want.clipped) begin
          $display("%0t: clipped expected %0b actual %0b", $time,
                   want.clipped, results.clipped);
          errors++;
        end
        words_checked++;
        if (want.clipped) clips_seen++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("pcm_gain_ramp_saturate_top_tb NOT OK");
      $finish;
    end
  end

  initial begin
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_index           = REG_CHANNEL_COUNT;
    cfg_wdata           = '0;
    samples.valid       = 1'b0;
    samples.sample      = '0;
    samples.frame_start = 1'b0;
    samples.start_gain  = '0;
    samples.end_gain    = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_directed_modes();
    test_register_limits();
    test_output_stall();
    test_random_frames(520, 1'b1);
    test_random_frames(80, 1'b0);

    wait_drained();
    repeat (20) @(posedge clk);
    $display("%0d words checked across %0d frame starts, %0d of them clipped;",
             words_checked, frames_started, clips_seen);
    $display("%0d register writes covering pass, constant and ramp modes", reg_writes);
    if (errors == 0) begin
      $display("pcm_gain_ramp_saturate_top_tb OK");
    end else begin
      $display("pcm_gain_ramp_saturate_top_tb NOT OK");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/pgrs_pkg.sv
sv/pgrs_if.sv
sv/pgrs_div.sv
sv/pgrs_front.sv
sv/pgrs_queue.sv
sv/pgrs_back.sv
sv/pcm_gain_ramp_saturate_top.sv
sv/pgrs_checker.sv
dv/pcm_gain_ramp_saturate_top_tb.sv
